// ===== rtl/core/fixed_point_alu_defines.svh =====
// Assertion macros shared by the fixed-point ALU RTL.
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

// Consequent must hold whenever the antecedent does.
`define FPA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Expression must hold on every clock edge outside reset.
`define FPA_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

// ===== rtl/core/fpa_pkg.sv =====
// Package: opcodes, error codes, pipeline word type and helpers for the fixed-point ALU.
package fpa_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int DIV_STEPS     = 32;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK   = 2'd0,
		ERR_OVF  = 2'd1,
		ERR_DIVZ = 2'd2
	} err_t;

	localparam logic [31:0] RAW_MAX = 32'h7fff_ffff;
	localparam logic [31:0] RAW_MIN = 32'h8000_0000;

	// One word in flight through the divider chain.
	typedef struct packed {
		logic        valid;
		logic        is_div;
		logic        is_mul;
		logic        neg;
		logic        div_zero;
		logic        div_ovf;
		logic [31:0] res;
		logic        cmp;
		err_t        err;
		logic [31:0] rem;
		logic [31:0] den;
		logic [31:0] lo;
		logic [31:0] quo;
	} pipe_t;

	// Apply sign to an unsigned magnitude and saturate; returns {ovf, value}.
	function automatic logic [32:0] sat_mag(input logic [63:0] m, input logic neg);
		logic [32:0] r;
		if (neg) begin
			if (m > 64'h0000_0000_8000_0000) r = {1'b1, RAW_MIN};
			else r = {1'b0, 32'd0 - m[31:0]};
		end else begin
			if (m > 64'h0000_0000_7fff_ffff) r = {1'b1, RAW_MAX};
			else r = {1'b0, m[31:0]};
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/fpa_div_step.sv =====
// One restoring-division step: shifts in one numerator bit, retires one quotient bit.
module fpa_div_step (
	input  fpa_pkg::pipe_t d,
	output fpa_pkg::pipe_t q
);
	import fpa_pkg::*;

	logic [32:0] trial;
	logic        ge;

	assign trial = {d.rem, d.lo[31]};
	assign ge    = trial >= {1'b0, d.den};

	always_comb begin
		q     = d;
		q.rem = ge ? 32'(trial - {1'b0, d.den}) : trial[31:0];
		q.lo  = {d.lo[30:0], 1'b0};
		q.quo = {d.quo[30:0], ge};
	end

endmodule

// ===== rtl/core/fixed_point_alu.sv =====
// Top level: pipelined signed fixed-point ALU.
// Every opcode passes through the stage-1 register, the divider stage registers and the output register to done.
// Throughput: one word per cycle; busy is held low, so start may be high every cycle.
// The 32 single-bit divider stages set the depth; the other ops ride the same chain.
// Reset (arst_n low) clears all valid bits at once; payload registers are not reset.
// The receiver cannot stall: each result shows for exactly one cycle with done high.
`include "fixed_point_alu_defines.svh"

module fixed_point_alu #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  kind,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic        done,
	output logic signed [31:0] result,
	output logic        compare_true,
	output logic [1:0]  error_code
);
	import fpa_pkg::*;

	localparam logic [63:0] MUL_HALF = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;
	localparam logic [32:0] TOINT_BIAS = 33'((64'd1 << FRAC_BITS) - 64'd1);

	// Nothing ever holds the pipe.
	assign busy = 1'b0;

	// ---------------- Stage 1: decode, simple ops, divider setup ----------------
	op_t         op;
	logic [32:0] ext_a, ext_b, sum, dif, incv, decv, tint;
	logic [63:0] wide_a, fromi, num64;
	logic [31:0] mag_a, mag_b;
	logic        lt_ab;
	pipe_t       s1_d;

	assign op     = op_t'(kind);
	assign ext_a  = {operand_a[31], operand_a};
	assign ext_b  = {operand_b[31], operand_b};
	assign sum    = ext_a + ext_b;
	assign dif    = ext_a - ext_b;
	assign incv   = ext_a + 33'd1;
	assign decv   = ext_a - 33'd1;
	// truncate toward zero: bias negatives before the arithmetic shift
	assign tint   = $signed(ext_a + (operand_a[31] ? TOINT_BIAS : 33'd0)) >>> FRAC_BITS;
	assign wide_a = {{32{operand_a[31]}}, operand_a};
	assign fromi  = wide_a << FRAC_BITS;
	assign mag_a  = operand_a[31] ? 32'd0 - operand_a : operand_a;
	assign mag_b  = operand_b[31] ? 32'd0 - operand_b : operand_b;
	assign num64  = {32'd0, mag_a} << FRAC_BITS;
	assign lt_ab  = operand_a < operand_b;

	always_comb begin
		s1_d          = '0;
		s1_d.valid    = start && !busy;
		s1_d.is_div   = op == OP_DIV;
		s1_d.is_mul   = op == OP_MUL;
		s1_d.neg      = operand_a[31] ^ operand_b[31];
		s1_d.div_zero = operand_b == 32'sd0;
		// quotient would need more than 32 bits: saturate without dividing
		s1_d.div_ovf  = num64[63:32] >= mag_b;
		s1_d.rem      = num64[63:32];
		s1_d.lo       = num64[31:0];
		s1_d.den      = mag_b;
		s1_d.err      = ERR_OK;
		unique case (op)
			OP_ADD: begin
				s1_d.res = (sum[32] != sum[31]) ? (sum[32] ? RAW_MIN : RAW_MAX) : sum[31:0];
				s1_d.err = (sum[32] != sum[31]) ? ERR_OVF : ERR_OK;
			end
			OP_SUB: begin
				s1_d.res = (dif[32] != dif[31]) ? (dif[32] ? RAW_MIN : RAW_MAX) : dif[31:0];
				s1_d.err = (dif[32] != dif[31]) ? ERR_OVF : ERR_OK;
			end
			OP_INC: begin
				s1_d.res = (incv[32] != incv[31]) ? RAW_MAX : incv[31:0];
				s1_d.err = (incv[32] != incv[31]) ? ERR_OVF : ERR_OK;
			end
			OP_DEC: begin
				s1_d.res = (decv[32] != decv[31]) ? RAW_MIN : decv[31:0];
				s1_d.err = (decv[32] != decv[31]) ? ERR_OVF : ERR_OK;
			end
			OP_GT:  s1_d.cmp = operand_a > operand_b;
			OP_LT:  s1_d.cmp = lt_ab;
			OP_GE:  s1_d.cmp = operand_a >= operand_b;
			OP_LE:  s1_d.cmp = operand_a <= operand_b;
			OP_EQ:  s1_d.cmp = operand_a == operand_b;
			OP_NE:  s1_d.cmp = operand_a != operand_b;
			OP_MIN: s1_d.res = lt_ab ? operand_a : operand_b;
			OP_MAX: s1_d.res = (operand_a > operand_b) ? operand_a : operand_b;
			OP_TOINT: s1_d.res = tint[31:0];
			OP_FROMINT: begin
				if ($signed(fromi) > $signed({32'd0, RAW_MAX})) begin
					s1_d.res = RAW_MAX;
					s1_d.err = ERR_OVF;
				end else if ($signed(fromi) < $signed({32'hffff_ffff, RAW_MIN})) begin
					s1_d.res = RAW_MIN;
					s1_d.err = ERR_OVF;
				end else begin
					s1_d.res = fromi[31:0];
				end
			end
			OP_MUL, OP_DIV: s1_d.res = 32'd0;
			default: s1_d.res = 32'd0;
		endcase
	end

	pipe_t       stg_s [0:DIV_STEPS];
	logic [31:0] mag_a_s1, mag_b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_s[0].valid <= 1'b0;
		end else begin
			stg_s[0] <= s1_d;
		end
	end

	always_ff @(posedge clk) begin
		mag_a_s1 <= mag_a;
		mag_b_s1 <= mag_b;
	end

	// ---------------- Multiply: product, then round and saturate ----------------
	logic [63:0] prod_s2;
	logic [32:0] mul_s3;   // {ovf, value}
	logic [63:0] mul_rnd;

	assign mul_rnd = (prod_s2 + MUL_HALF) >> FRAC_BITS;

	always_ff @(posedge clk) begin
		prod_s2 <= mag_a_s1 * mag_b_s1;
		mul_s3  <= sat_mag(mul_rnd, stg_s[1].neg);
	end

	// ---------------- Divider chain, one quotient bit per stage ----------------
	genvar j;
	generate
		for (j = 1; j <= DIV_STEPS; j++) begin : g_div
			pipe_t step_q, nxt;

			fpa_div_step u_step (
				.d (stg_s[j-1]),
				.q (step_q)
			);

			// multiply result joins the chain once it is ready
			if (j == 3) begin : g_mul_join
				always_comb begin
					nxt = step_q;
					if (step_q.is_mul) begin
						nxt.res = mul_s3[31:0];
						nxt.err = mul_s3[32] ? ERR_OVF : ERR_OK;
					end
				end
			end else begin : g_pass
				assign nxt = step_q;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					stg_s[j].valid <= 1'b0;
				end else begin
					stg_s[j] <= nxt;
				end
			end
		end
	endgenerate

	// ---------------- Output stage: divide rounding and result register ----------------
	pipe_t       last;
	logic        rnd_up;
	logic [32:0] div_sat;
	logic [31:0] res_d;
	err_t        err_d;

	assign last    = stg_s[DIV_STEPS];
	// round half away from zero on the magnitude: remainder*2 >= divisor
	assign rnd_up  = {last.rem, 1'b0} >= {1'b0, last.den};
	assign div_sat = sat_mag({32'd0, last.quo} + {63'd0, rnd_up}, last.neg);

	always_comb begin
		res_d = last.res;
		err_d = last.err;
		if (last.is_div) begin
			priority if (last.div_zero) begin
				res_d = last.neg ^ last.den[31] ? RAW_MIN : RAW_MAX;
				err_d = ERR_DIVZ;
			end else if (last.div_ovf) begin
				res_d = last.neg ? RAW_MIN : RAW_MAX;
				err_d = ERR_OVF;
			end else begin
				res_d = div_sat[31:0];
				err_d = div_sat[32] ? ERR_OVF : ERR_OK;
			end
		end
	end

	logic        done_q;
	logic [31:0] result_q;
	logic        cmp_q;
	err_t        err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
		cmp_q    <= last.cmp;
		err_q    <= err_d;
	end

	assign done         = done_q;
	assign result       = result_q;
	assign compare_true = cmp_q;
	assign error_code   = err_q;

	// ---------------- Assertions ----------------
	// history from before the first edges counts as an empty pipe
	`FPA_ASSERT_ALWAYS(a_latency, done == ($past(stg_s[0].valid, DIV_STEPS + 1) === 1'b1), "done out of step with pipe")
	`FPA_ASSERT_IMPL(a_cmp_zero, done && compare_true, result == 32'd0, "compare with nonzero result")
	`FPA_ASSERT_IMPL(a_err_code, done, error_code != 2'd3, "illegal error code")
	`FPA_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule
